// File: rtl/core/tbp_pkg.sv
// Shared types and constants for the token bucket policer.
package tbp_pkg;

	localparam int TBP_TOKEN_WIDTH = 32;

	localparam int TBP_ADDR_W = 3;
	localparam int TBP_DATA_W = 32;

	localparam logic [0:0] REG_RATE  = 1'b0;
	localparam logic [0:0] REG_BURST = 1'b1;

	localparam logic [31:0] RESET_RATE  = 32'd1000000;
	localparam logic [31:0] RESET_BURST = 32'd65536;

	localparam logic [31:0] NS_PER_SEC = 32'd1000000000;

	// Reciprocal of one second, floor(2^61 / 1e9), for the quotient estimate.
	localparam logic [31:0] RECIP_NS = 32'd2305843009;

	// A product of 2^32 seconds' worth of tokens or more exceeds any burst.
	localparam logic [63:0] SAT_PROD = 64'd4294967296000000000;

	// Product of rate and elapsed time, and the quotient of that by one second.
	localparam int PROD_W = 96;
	localparam int QUO_W  = 33;
	localparam int SUM_W  = 65;
	localparam int REM_W  = 34;

	typedef struct packed {
		logic load;
		logic check;
		logic fill;
		logic mul_lo;
		logic mul_hi;
		logic add;
		logic est;
		logic back;
		logic fix;
		logic sum;
		logic clamp;
		logic judge;
	} tbp_cmd_t;

	typedef struct packed {
		logic start;
		logic advance;
	} tbp_status_t;

endpackage

// File: rtl/core/tbp_regs.sv
// Configuration registers behind the APB-style port.
module tbp_regs
	import tbp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [TBP_ADDR_W-1:0] paddr,
	input  logic [TBP_DATA_W-1:0] pwdata,
	output logic [TBP_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [31:0]           rate_bytes_per_second,
	output logic [31:0]           burst_limit
);

	logic [31:0] rate_q;
	logic [31:0] burst_q;
	logic        wr_en;
	logic [0:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[2:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= RESET_RATE;
			burst_q <= RESET_BURST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RATE:  rate_q  <= pwdata;
				REG_BURST: burst_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RATE:  prdata = rate_q;
			REG_BURST: prdata = burst_q;
			default:   prdata = '0;
		endcase
	end

	assign rate_bytes_per_second = rate_q;
	assign burst_limit           = burst_q;

endmodule

// File: rtl/core/tbp_dp.sv
// Datapath: bucket state, refill multiply, divide by one second, clamp and judge.
module tbp_dp
	import tbp_pkg::*;
#(
	parameter int TOKEN_WIDTH = TBP_TOKEN_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tbp_cmd_t    cmd,
	output tbp_status_t status,
	input  logic [63:0] now_ns,
	input  logic [15:0] packet_length,
	input  logic [31:0] rate_bytes_per_second,
	input  logic [31:0] burst_limit,
	output logic        pass
);

	localparam int CW = (TOKEN_WIDTH > 32) ? TOKEN_WIDTH : 32;

	localparam logic [REM_W-1:0] REM_1S  = REM_W'(NS_PER_SEC);
	localparam logic [REM_W-1:0] REM_2S  = REM_1S + REM_1S;
	localparam logic [REM_W-1:0] REM_3S  = REM_2S + REM_1S;
	localparam logic [REM_W-1:0] REM_4S  = REM_2S + REM_2S;
	localparam logic [QUO_W-1:0] QUO_SAT = QUO_W'(64'd1 << 32);

	logic [63:0]            now_q;
	logic [63:0]            last_q;
	logic [15:0]            len_q;
	logic [TOKEN_WIDTH-1:0] tokens_q;
	logic [63:0]            elapsed_q;
	logic [PROD_W-1:0]      prod_q;
	logic [63:0]            pp_q;
	logic [31:0]            est_q;
	logic                   sat_q;
	logic [REM_W-1:0]       rem_q;
	logic [QUO_W-1:0]       quo_q;
	logic [SUM_W-1:0]       sum_q;
	logic                   pass_q;

	logic [TOKEN_WIDTH-1:0] tok_max;
	logic [CW-1:0]          burst_w;
	logic [CW-1:0]          tmax_w;
	logic [TOKEN_WIDTH-1:0] cap;
	logic [31:0]            mul_a;
	logic [31:0]            mul_b;
	logic [63:0]            mul_p;
	logic [2:0]             fix_inc;
	logic [TOKEN_WIDTH-1:0] len_w;
	logic                   enough;

	assign tok_max = '1;
	assign burst_w = CW'(burst_limit);
	assign tmax_w  = CW'(tok_max);
	assign cap     = (burst_w < tmax_w) ? TOKEN_WIDTH'(burst_w) : tok_max;

	assign status.start   = (last_q == 64'd0);
	assign status.advance = (now_q > last_q);

	// One multiplier serves both halves of the elapsed time, the quotient
	// estimate and the back-multiply that yields the remainder.
	always_comb begin
		mul_a = rate_bytes_per_second;
		mul_b = elapsed_q[31:0];
		if (cmd.mul_hi) begin
			mul_b = elapsed_q[63:32];
		end else if (cmd.est) begin
			mul_a = prod_q[61:30];
			mul_b = RECIP_NS;
		end else if (cmd.back) begin
			mul_a = est_q;
			mul_b = NS_PER_SEC;
		end
	end

	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// The estimate from the upper product bits falls short of the true
	// quotient by at most four, so the remainder settles the last step.
	assign fix_inc = 3'(rem_q >= REM_1S) + 3'(rem_q >= REM_2S) +
		3'(rem_q >= REM_3S) + 3'(rem_q >= REM_4S);

	assign len_w  = TOKEN_WIDTH'(len_q);
	assign enough = (tokens_q >= len_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			tokens_q <= '0;
		end else begin
			if (cmd.fill) begin
				last_q   <= now_q;
				tokens_q <= cap;
			end
			if (cmd.clamp) begin
				last_q   <= now_q;
				tokens_q <= (sum_q > SUM_W'(cap)) ? cap : sum_q[TOKEN_WIDTH-1:0];
			end
			if (cmd.judge && enough) begin
				tokens_q <= tokens_q - len_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q <= now_ns;
			len_q <= packet_length;
		end
		if (cmd.check) begin
			elapsed_q <= now_q - last_q;
		end
		if (cmd.mul_lo) begin
			prod_q <= PROD_W'(mul_p);
		end
		if (cmd.mul_hi) begin
			pp_q <= mul_p;
		end
		if (cmd.add) begin
			prod_q <= prod_q + {pp_q, 32'd0};
		end
		if (cmd.est) begin
			est_q <= mul_p[62:31];
			sat_q <= (prod_q >= PROD_W'(SAT_PROD));
		end
		if (cmd.back) begin
			rem_q <= prod_q[REM_W-1:0] - mul_p[REM_W-1:0];
		end
		if (cmd.fix) begin
			quo_q <= sat_q ? QUO_SAT : QUO_W'(est_q) + QUO_W'(fix_inc);
		end
		if (cmd.sum) begin
			sum_q <= SUM_W'(tokens_q) + SUM_W'(quo_q);
		end
		if (cmd.judge) begin
			pass_q <= enough;
		end
	end

	assign pass = pass_q;

endmodule

// File: rtl/core/tbp_ctrl.sv
// Controller: sequences one packet through check, refill and judge.
module tbp_ctrl
	import tbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  tbp_status_t status,
	output tbp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FILL,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ADD,
		ST_EST,
		ST_BACK,
		ST_FIX,
		ST_SUM,
		ST_CLAMP,
		ST_JUDGE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// The result register is free if empty or its beat leaves this cycle.
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.check  = (state_q == ST_CHECK);
		cmd.fill   = (state_q == ST_FILL);
		cmd.mul_lo = (state_q == ST_MUL_LO);
		cmd.mul_hi = (state_q == ST_MUL_HI);
		cmd.add    = (state_q == ST_ADD);
		cmd.est    = (state_q == ST_EST);
		cmd.back   = (state_q == ST_BACK);
		cmd.fix    = (state_q == ST_FIX);
		cmd.sum    = (state_q == ST_SUM);
		cmd.clamp  = (state_q == ST_CLAMP);
		cmd.judge  = (state_q == ST_JUDGE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.judge) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (status.start) begin
						state_q <= ST_FILL;
					end else if (!status.advance) begin
						state_q <= ST_JUDGE;
					end else begin
						state_q <= ST_MUL_LO;
					end
				end
				ST_FILL:   state_q <= ST_JUDGE;
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_ADD;
				ST_ADD:    state_q <= ST_EST;
				ST_EST:    state_q <= ST_BACK;
				ST_BACK:   state_q <= ST_FIX;
				ST_FIX:    state_q <= ST_SUM;
				ST_SUM:    state_q <= ST_CLAMP;
				ST_CLAMP:  state_q <= ST_JUDGE;
				ST_JUDGE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/token_bucket_policer.sv
// Token bucket policer top level: one pass/drop beat per packet beat.
// Each packet is loaded and checked: the first packet fills the bucket, a timestamp that
// does not advance goes straight to the judge, and otherwise tokens are refilled first.
// A refill takes a two-pass 32x32 product, then a reciprocal multiply and a back-multiply
// for the divide by one second; input stalls until the previous packet has been judged.
// Reset clears the bucket to empty and not started, and loads default registers.
module token_bucket_policer
	import tbp_pkg::*;
#(
	parameter int TOKEN_WIDTH = TBP_TOKEN_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [63:0]           now_ns,
	input  logic [15:0]           packet_length,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  pass,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [TBP_ADDR_W-1:0] paddr,
	input  logic [TBP_DATA_W-1:0] pwdata,
	output logic [TBP_DATA_W-1:0] prdata,
	output logic                  pready
);

	tbp_cmd_t    cmd;
	tbp_status_t status;
	logic [31:0] rate_bytes_per_second;
	logic [31:0] burst_limit;

	tbp_regs u_regs (
		.clk                   (clk),
		.arst_n                (arst_n),
		.psel                  (psel),
		.penable               (penable),
		.pwrite                (pwrite),
		.paddr                 (paddr),
		.pwdata                (pwdata),
		.prdata                (prdata),
		.pready                (pready),
		.rate_bytes_per_second (rate_bytes_per_second),
		.burst_limit           (burst_limit)
	);

	tbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	tbp_dp #(
		.TOKEN_WIDTH (TOKEN_WIDTH)
	) u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.status                (status),
		.now_ns                (now_ns),
		.packet_length         (packet_length),
		.rate_bytes_per_second (rate_bytes_per_second),
		.burst_limit           (burst_limit),
		.pass                  (pass)
	);

endmodule
